// File: design/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and helpers for the polled I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Payload length counter width
  localparam int CountBits = 16;

  // Most results one transaction can cause
  localparam int ResMax  = 5;
  localparam int IdxBits = $clog2(ResMax);
  localparam int CntBits = $clog2(ResMax + 1);

  // Sequencer phase codes
  localparam int PhaseBits = 4;
  localparam logic [PhaseBits-1:0] PH_IDLE  = 4'd0;
  localparam logic [PhaseBits-1:0] PH_BUSY  = 4'd1;
  localparam logic [PhaseBits-1:0] PH_SB    = 4'd2;
  localparam logic [PhaseBits-1:0] PH_ADDR  = 4'd3;
  localparam logic [PhaseBits-1:0] PH_REG   = 4'd4;
  localparam logic [PhaseBits-1:0] PH_DATA  = 4'd5;
  localparam logic [PhaseBits-1:0] PH_BTFTX = 4'd6;
  localparam logic [PhaseBits-1:0] PH_REG2  = 4'd7;
  localparam logic [PhaseBits-1:0] PH_SB2   = 4'd8;
  localparam logic [PhaseBits-1:0] PH_ADDR2 = 4'd9;
  localparam logic [PhaseBits-1:0] PH_RXONE = 4'd10;
  localparam logic [PhaseBits-1:0] PH_RXN   = 4'd11;
  localparam logic [PhaseBits-1:0] PH_RXBTF = 4'd12;

  // Request types
  localparam logic REQ_CMD  = 1'b0;
  localparam logic REQ_SNAP = 1'b1;

  // Command kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REGWR  = 2'd2;
  localparam logic [1:0] KIND_REGRD  = 2'd3;

  // Status flag bit positions
  localparam int FL_BUSY = 0;
  localparam int FL_SB   = 1;
  localparam int FL_ADDR = 2;
  localparam int FL_TXE  = 3;
  localparam int FL_BTF  = 4;
  localparam int FL_RXNE = 5;
  localparam int FL_AF   = 6;
  localparam int FL_BERR = 7;

  // Action codes
  localparam logic [3:0] ACT_START   = 4'd0;
  localparam logic [3:0] ACT_ABYTE   = 4'd1;
  localparam logic [3:0] ACT_PAY     = 4'd2;
  localparam logic [3:0] ACT_STOP    = 4'd3;
  localparam logic [3:0] ACT_ACKON   = 4'd4;
  localparam logic [3:0] ACT_ACKOFF  = 4'd5;
  localparam logic [3:0] ACT_CLRAF   = 4'd6;
  localparam logic [3:0] ACT_CLRBERR = 4'd7;
  localparam logic [3:0] ACT_CLRADDR = 4'd8;
  localparam logic [3:0] ACT_RX      = 4'd9;
  localparam logic [3:0] ACT_DONE    = 4'd10;

  // Input transaction
  typedef struct packed {
    logic       req_type;
    logic [1:0] kind;
    logic [6:0] target_address;
    logic [7:0] register_address;
    logic [15:0] byte_count;
    logic       stop_after;
    logic [7:0] status_flags;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [7:0] rx_byte_second;
  } req_t;

  // Output transaction
  typedef struct packed {
    logic [3:0] action;
    logic [7:0] data_byte;
    logic       status;
    logic       last;
  } act_t;

  // Saved transaction context
  typedef struct packed {
    logic [1:0]           op_kind;
    logic [6:0]           saved_target;
    logic [7:0]           saved_register;
    logic [CountBits-1:0] bytes_left;
    logic                 stop_wanted;
  } ctx_t;

  // Results of one step, handed to the output buffer
  typedef struct packed {
    logic [CntBits-1:0]     count;
    act_t [ResMax-1:0]      items;
  } bundle_t;

  // Build one result entry; last is set by the output buffer
  function automatic act_t mk_act(logic [3:0] action, logic [7:0] data, logic status);
    act_t a;
    a.action    = action;
    a.data_byte = data;
    a.status    = status;
    a.last      = 1'b0;
    return a;
  endfunction

endpackage

// File: design/i2cm_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_step
// Next phase, context and result list for one registered transaction.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::req_t                   req,
  input  logic [i2cm_pkg::PhaseBits-1:0]   phase,
  input  i2cm_pkg::ctx_t                   ctx,
  output logic [i2cm_pkg::PhaseBits-1:0]   phase_next,
  output i2cm_pkg::ctx_t                   ctx_next,
  output i2cm_pkg::bundle_t                bundle
);

  always_comb begin
    logic [i2cm_pkg::CntBits-1:0]   n;
    i2cm_pkg::act_t [i2cm_pkg::ResMax-1:0] items;
    logic [i2cm_pkg::CountBits-1:0] len;
    logic [i2cm_pkg::CountBits-1:0] bl_dec;
    logic [7:0]                     f;
    logic                           rd;
    logic                           do_fail;
    logic                           fail_af;
    logic                           do_finish;
    logic                           do_recv;

    phase_next = phase;
    ctx_next   = ctx;
    n          = '0;
    items      = '0;
    do_fail    = 1'b0;
    fail_af    = 1'b0;
    do_finish  = 1'b0;
    do_recv    = 1'b0;
    f          = req.status_flags;
    len        = i2cm_pkg::CountBits'(req.byte_count);
    bl_dec     = ctx.bytes_left - i2cm_pkg::CountBits'(1);
    rd         = (phase == i2cm_pkg::PH_SB2) || (ctx.op_kind == i2cm_pkg::KIND_READ);

    if (req.req_type == i2cm_pkg::REQ_CMD) begin
      // Command: only taken while idle, zero length fails at once
      if (phase == i2cm_pkg::PH_IDLE) begin
        if (len == '0) begin
          items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_DONE, 8'd0, 1'b1);
          n = n + 1'b1;
        end else begin
          ctx_next.op_kind        = req.kind;
          ctx_next.saved_target   = req.target_address;
          ctx_next.saved_register = req.register_address;
          ctx_next.bytes_left     = len;
          ctx_next.stop_wanted    = req.kind[1] ? 1'b1 : req.stop_after;
          phase_next              = i2cm_pkg::PH_BUSY;
        end
      end
    end else if (phase != i2cm_pkg::PH_IDLE) begin
      // Snapshot: resolve at most one wait
      unique case (phase)
        i2cm_pkg::PH_BUSY: begin
          if (!f[i2cm_pkg::FL_BUSY]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_START, 8'd0, 1'b0);
            n = n + 1'b1;
            phase_next = i2cm_pkg::PH_SB;
          end
        end
        i2cm_pkg::PH_SB, i2cm_pkg::PH_SB2: begin
          if (f[i2cm_pkg::FL_SB]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_ABYTE, {ctx.saved_target, rd}, 1'b0);
            n = n + 1'b1;
            phase_next = (phase == i2cm_pkg::PH_SB2) ? i2cm_pkg::PH_ADDR2 : i2cm_pkg::PH_ADDR;
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        i2cm_pkg::PH_ADDR: begin
          if (f[i2cm_pkg::FL_ADDR]) begin
            if (ctx.op_kind == i2cm_pkg::KIND_READ) begin
              do_recv = 1'b1;
            end else begin
              items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_CLRADDR, 8'd0, 1'b0);
              n = n + 1'b1;
              phase_next = (ctx.op_kind == i2cm_pkg::KIND_WRITE) ? i2cm_pkg::PH_DATA
                                                                 : i2cm_pkg::PH_REG;
            end
          end else if (f[i2cm_pkg::FL_AF]) begin
            do_fail = 1'b1;
            fail_af = 1'b1;
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        i2cm_pkg::PH_ADDR2: begin
          if (f[i2cm_pkg::FL_ADDR]) begin
            do_recv = 1'b1;
          end else if (f[i2cm_pkg::FL_AF]) begin
            do_fail = 1'b1;
            fail_af = 1'b1;
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        i2cm_pkg::PH_REG: begin
          if (f[i2cm_pkg::FL_TXE]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_ABYTE, ctx.saved_register, 1'b0);
            n = n + 1'b1;
            phase_next = (ctx.op_kind == i2cm_pkg::KIND_REGRD) ? i2cm_pkg::PH_REG2
                                                               : i2cm_pkg::PH_DATA;
          end else if (f[i2cm_pkg::FL_AF]) begin
            do_fail = 1'b1;
            fail_af = 1'b1;
          end
        end
        i2cm_pkg::PH_DATA: begin
          if (f[i2cm_pkg::FL_TXE]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_PAY, req.tx_byte, 1'b0);
            n = n + 1'b1;
            ctx_next.bytes_left = bl_dec;
            if (bl_dec == '0) begin
              phase_next = i2cm_pkg::PH_BTFTX;
            end
          end else if (f[i2cm_pkg::FL_AF]) begin
            do_fail = 1'b1;
            fail_af = 1'b1;
          end
        end
        i2cm_pkg::PH_BTFTX: begin
          if (f[i2cm_pkg::FL_BTF]) begin
            do_finish = 1'b1;
          end
        end
        i2cm_pkg::PH_REG2: begin
          if (f[i2cm_pkg::FL_TXE]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_START, 8'd0, 1'b0);
            n = n + 1'b1;
            phase_next = i2cm_pkg::PH_SB2;
          end else if (f[i2cm_pkg::FL_AF]) begin
            do_fail = 1'b1;
            fail_af = 1'b1;
          end
        end
        i2cm_pkg::PH_RXONE: begin
          if (f[i2cm_pkg::FL_RXNE]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_RX, req.rx_byte, 1'b0);
            n = n + 1'b1;
            do_finish = 1'b1;
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        i2cm_pkg::PH_RXN: begin
          if (f[i2cm_pkg::FL_RXNE]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_RX, req.rx_byte, 1'b0);
            n = n + 1'b1;
            ctx_next.bytes_left = bl_dec;
            if (bl_dec <= i2cm_pkg::CountBits'(2)) begin
              phase_next = i2cm_pkg::PH_RXBTF;
            end
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        i2cm_pkg::PH_RXBTF: begin
          // last two bytes read back to back with ACK off first
          if (f[i2cm_pkg::FL_BTF]) begin
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_ACKOFF, 8'd0, 1'b0);
            n = n + 1'b1;
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_RX, req.rx_byte, 1'b0);
            n = n + 1'b1;
            items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_RX, req.rx_byte_second, 1'b0);
            n = n + 1'b1;
            ctx_next.bytes_left = '0;
            do_finish = 1'b1;
          end else if (f[i2cm_pkg::FL_BERR]) begin
            do_fail = 1'b1;
          end
        end
        default: begin
          phase_next = i2cm_pkg::PH_IDLE;
        end
      endcase
    end

    // Receive set-up after ADDR: single byte turns ACK off before clearing ADDR
    if (do_recv) begin
      if (ctx.bytes_left == i2cm_pkg::CountBits'(1)) begin
        items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_ACKOFF, 8'd0, 1'b0);
        n = n + 1'b1;
        phase_next = i2cm_pkg::PH_RXONE;
      end else begin
        items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_ACKON, 8'd0, 1'b0);
        n = n + 1'b1;
        phase_next = (ctx.bytes_left == i2cm_pkg::CountBits'(2)) ? i2cm_pkg::PH_RXBTF
                                                                 : i2cm_pkg::PH_RXN;
      end
      items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_CLRADDR, 8'd0, 1'b0);
      n = n + 1'b1;
    end

    // Normal end of transaction
    if (do_finish) begin
      if (ctx.stop_wanted) begin
        items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_STOP, 8'd0, 1'b0);
        n = n + 1'b1;
      end
      items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_DONE, 8'd0, 1'b0);
      n = n + 1'b1;
      phase_next = i2cm_pkg::PH_IDLE;
    end

    // Error end: clear the flag, stop the bus, report failure
    if (do_fail) begin
      items[n] = i2cm_pkg::mk_act(fail_af ? i2cm_pkg::ACT_CLRAF : i2cm_pkg::ACT_CLRBERR,
                                  8'd0, 1'b0);
      n = n + 1'b1;
      items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_STOP, 8'd0, 1'b0);
      n = n + 1'b1;
      items[n] = i2cm_pkg::mk_act(i2cm_pkg::ACT_DONE, 8'd0, 1'b1);
      n = n + 1'b1;
      phase_next = i2cm_pkg::PH_IDLE;
    end

    bundle.count = n;
    bundle.items = items;
  end

endmodule

// File: design/i2cm_res_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_res_buf
// Result register: holds one step's results and hands them out in order.
// ----------------------------------------------------------------------------
module i2cm_res_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  i2cm_pkg::bundle_t  bundle,
  output logic               free,
  output logic               act_valid,
  input  logic               act_ready,
  output i2cm_pkg::act_t     act
);

  i2cm_pkg::act_t [i2cm_pkg::ResMax-1:0] items;
  logic [i2cm_pkg::CntBits-1:0]          cnt;
  logic [i2cm_pkg::IdxBits-1:0]          idx;
  logic                                  is_last;
  logic                                  take;

  // Output side
  assign is_last   = (i2cm_pkg::CntBits'(idx) == (cnt - 1'b1));
  assign act_valid = (cnt != '0);
  assign take      = act_valid && act_ready;
  assign free      = (cnt == '0) || (take && is_last);

  always_comb begin
    act      = items[idx];
    act.last = is_last;
  end

  // Count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load) begin
      cnt <= bundle.count;
      idx <= '0;
    end else if (take) begin
      if (is_last) begin
        cnt <= '0;
        idx <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (load) begin
      items <= bundle.items;
    end
  end

endmodule

// File: design/i2c_master_transaction_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// A taken transaction waits in the input register until the result register is
// free. The output register drains one result per cycle while act_ready is high,
// which sets the rate: one transaction per cycle while each causes at most one
// result; one with more results holds the result register until all are taken.
// Reset (rst, synchronous) returns the phase to idle and clears the context.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  i2cm_pkg::req_t   req,
  output logic             act_valid,
  input  logic             act_ready,
  output i2cm_pkg::act_t   act
);

  i2cm_pkg::req_t                  req_q;
  logic                            req_v;
  logic [i2cm_pkg::PhaseBits-1:0]  phase;
  logic [i2cm_pkg::PhaseBits-1:0]  phase_next;
  i2cm_pkg::ctx_t                  ctx;
  i2cm_pkg::ctx_t                  ctx_next;
  i2cm_pkg::bundle_t               bundle;
  logic                            buf_free;
  logic                            advance;

  // Registered transaction moves on once the result register can take it
  assign advance   = req_v && buf_free;
  assign req_ready = !req_v || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_v <= 1'b0;
    end else if (req_ready) begin
      req_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cm_pkg::PH_IDLE;
      ctx   <= '0;
    end else if (advance) begin
      phase <= phase_next;
      ctx   <= ctx_next;
    end
  end

  i2cm_step u_step (
    .req        (req_q),
    .phase      (phase),
    .ctx        (ctx),
    .phase_next (phase_next),
    .ctx_next   (ctx_next),
    .bundle     (bundle)
  );

  i2cm_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && (bundle.count != '0)),
    .bundle    (bundle),
    .free      (buf_free),
    .act_valid (act_valid),
    .act_ready (act_ready),
    .act       (act)
  );

endmodule

// File: design/i2cm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks on the sequencer's request and result channels.
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input i2cm_pkg::req_t   req,
  input logic             act_valid,
  input logic             act_ready,
  input i2cm_pkg::act_t   act
);

  // Stalled request holds
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    act_valid && !act_ready |=> act_valid && $stable(act))
    else $error("result changed while stalled");

  // Nothing pending straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !act_valid)
    else $error("result valid after reset");

  // Done always closes the results of its transaction
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    act_valid && (act.action == i2cm_pkg::ACT_DONE) |-> act.last)
    else $error("done not marked last");

  // Status and data only carried by the actions that own them
  a_fields: assert property (@(posedge clk) disable iff (rst)
    act_valid && (act.action != i2cm_pkg::ACT_ABYTE) && (act.action != i2cm_pkg::ACT_PAY)
      && (act.action != i2cm_pkg::ACT_RX) |-> (act.data_byte == 8'd0)
      && (act.status == 1'b0 || act.action == i2cm_pkg::ACT_DONE))
    else $error("stray data or status");

endmodule

bind i2c_master_transaction_sequencer_top i2cm_checker u_checker (.*);

// File: bench/i2c_master_transaction_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top_tb
// Self-checking bench for the polled I2C master sequencer. A short table of
// commands and status snapshots walks every transfer kind, the ACK rules and
// the error exits; random well-formed transfers with some noise follow. Every
// accepted transaction runs through a local sequencer copy; its predicted bus
// actions, or a row's hand-written ones, are matched in order to the output.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top_tb;

  localparam int RandItems      = 400;
  localparam int CalmItems      = 60;
  localparam int HoldAt         = 120;
  localparam int DrainAt        = 260;
  localparam int LongHoldCycles = 300;
  localparam int StallLimit     = 3000;
  localparam int TailCycles     = 20;

  // One directed row: stimulus plus an optional hand-written expectation
  typedef struct packed {
    i2cm_pkg::req_t       r;
    logic                 typed_on;
    logic [1:0]           n_typed;
    i2cm_pkg::act_t [2:0] typed;
  } drow_t;

  localparam i2cm_pkg::act_t NoAct = '0;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           req_valid = 1'b0;
  logic           act_ready = 1'b0;
  i2cm_pkg::req_t req       = '0;
  logic           req_ready;
  logic           act_valid;
  i2cm_pkg::act_t act;

  // Sequencer shadow state
  logic [i2cm_pkg::PhaseBits-1:0] ph       = i2cm_pkg::PH_IDLE;
  logic [1:0]                     p_kind   = '0;
  logic [6:0]                     p_target = '0;
  logic [7:0]                     p_reg    = '0;
  logic [i2cm_pkg::CountBits-1:0] p_left   = '0;
  logic                           p_stop   = 1'b0;

  i2cm_pkg::act_t step_acts [i2cm_pkg::ResMax];
  int             step_count;
  i2cm_pkg::act_t pending_actions [$];
  i2cm_pkg::act_t want;
  drow_t          plan [$];
  int             fails = 0;
  int             stall_cycles = 0;

  bit calm       = 1'b0;
  bit hold_long  = 1'b0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;

  i2c_master_transaction_sequencer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .act_valid (act_valid),
    .act_ready (act_ready),
    .act       (act)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- builders
  function automatic i2cm_pkg::act_t bus_act(logic [3:0] a, logic [7:0] d, logic s,
                                             logic l);
    i2cm_pkg::act_t x;
    x.action    = a;
    x.data_byte = d;
    x.status    = s;
    x.last      = l;
    return x;
  endfunction

  function automatic i2cm_pkg::req_t cmd(logic [1:0] k, logic [6:0] tgt, logic [7:0] rg,
                                         logic [15:0] len, logic stp);
    i2cm_pkg::req_t r;
    r                  = '0;
    r.req_type         = i2cm_pkg::REQ_CMD;
    r.kind             = k;
    r.target_address   = tgt;
    r.register_address = rg;
    r.byte_count       = len;
    r.stop_after       = stp;
    return r;
  endfunction

  function automatic i2cm_pkg::req_t snap(logic [7:0] fl, logic [7:0] tx, logic [7:0] rx1,
                                          logic [7:0] rx2);
    i2cm_pkg::req_t r;
    r                = '0;
    r.req_type       = i2cm_pkg::REQ_SNAP;
    r.status_flags   = fl;
    r.tx_byte        = tx;
    r.rx_byte        = rx1;
    r.rx_byte_second = rx2;
    return r;
  endfunction

  function automatic drow_t row(i2cm_pkg::req_t r);
    drow_t d;
    d   = '0;
    d.r = r;
    return d;
  endfunction

  function automatic drow_t lit(i2cm_pkg::req_t r, int n, i2cm_pkg::act_t a0,
                                i2cm_pkg::act_t a1, i2cm_pkg::act_t a2);
    drow_t d;
    d          = '0;
    d.r        = r;
    d.typed_on = 1'b1;
    d.n_typed  = 2'(n);
    d.typed[0] = a0;
    d.typed[1] = a1;
    d.typed[2] = a2;
    return d;
  endfunction

  // --------------------------------------------------------------- predictor
  task automatic add_act(logic [3:0] a, logic [7:0] d, logic s);
    if (step_count < i2cm_pkg::ResMax) begin
      step_acts[step_count] = bus_act(a, d, s, 1'b0);
      step_count++;
    end
  endtask

  // Error exit: clear the flag, release the bus, report failure
  task automatic abort_transfer(logic on_af);
    add_act(on_af ? i2cm_pkg::ACT_CLRAF : i2cm_pkg::ACT_CLRBERR, 8'h00, 1'b0);
    add_act(i2cm_pkg::ACT_STOP, 8'h00, 1'b0);
    add_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1);
    ph = i2cm_pkg::PH_IDLE;
  endtask

  task automatic wrap_up();
    if (p_stop)
      add_act(i2cm_pkg::ACT_STOP, 8'h00, 1'b0);
    add_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b0);
    ph = i2cm_pkg::PH_IDLE;
  endtask

  // ACK handling depends on how many bytes are still to come
  task automatic begin_receive();
    if (p_left == 1) begin
      add_act(i2cm_pkg::ACT_ACKOFF, 8'h00, 1'b0);
      add_act(i2cm_pkg::ACT_CLRADDR, 8'h00, 1'b0);
      ph = i2cm_pkg::PH_RXONE;
    end else begin
      add_act(i2cm_pkg::ACT_ACKON, 8'h00, 1'b0);
      add_act(i2cm_pkg::ACT_CLRADDR, 8'h00, 1'b0);
      ph = (p_left == 2) ? i2cm_pkg::PH_RXBTF : i2cm_pkg::PH_RXN;
    end
  endtask

  task automatic compute_bus_actions(input i2cm_pkg::req_t r);
    logic [7:0] fl;
    fl         = r.status_flags;
    step_count = 0;
    if (r.req_type == i2cm_pkg::REQ_CMD) begin
      if (ph == i2cm_pkg::PH_IDLE) begin
        if (r.byte_count == 0) begin
          add_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1);
        end else begin
          p_kind   = r.kind;
          p_target = r.target_address;
          p_reg    = r.register_address;
          p_left   = r.byte_count;
          p_stop   = (r.kind == i2cm_pkg::KIND_REGWR || r.kind == i2cm_pkg::KIND_REGRD)
                     ? 1'b1 : r.stop_after;
          ph       = i2cm_pkg::PH_BUSY;
        end
      end
    end else if (ph != i2cm_pkg::PH_IDLE) begin
      case (ph)
        i2cm_pkg::PH_BUSY: begin
          if (!fl[i2cm_pkg::FL_BUSY]) begin
            add_act(i2cm_pkg::ACT_START, 8'h00, 1'b0);
            ph = i2cm_pkg::PH_SB;
          end
        end
        i2cm_pkg::PH_SB, i2cm_pkg::PH_SB2: begin
          if (fl[i2cm_pkg::FL_SB]) begin
            add_act(i2cm_pkg::ACT_ABYTE,
                    {p_target, (ph == i2cm_pkg::PH_SB2 || p_kind == i2cm_pkg::KIND_READ)},
                    1'b0);
            ph = (ph == i2cm_pkg::PH_SB2) ? i2cm_pkg::PH_ADDR2 : i2cm_pkg::PH_ADDR;
          end else if (fl[i2cm_pkg::FL_BERR]) begin
            abort_transfer(1'b0);
          end
        end
        i2cm_pkg::PH_ADDR, i2cm_pkg::PH_ADDR2: begin
          if (fl[i2cm_pkg::FL_ADDR]) begin
            if (ph == i2cm_pkg::PH_ADDR2 || p_kind == i2cm_pkg::KIND_READ) begin
              begin_receive();
            end else begin
              add_act(i2cm_pkg::ACT_CLRADDR, 8'h00, 1'b0);
              ph = (p_kind == i2cm_pkg::KIND_WRITE) ? i2cm_pkg::PH_DATA : i2cm_pkg::PH_REG;
            end
          end else if (fl[i2cm_pkg::FL_AF]) begin
            abort_transfer(1'b1);
          end else if (fl[i2cm_pkg::FL_BERR]) begin
            abort_transfer(1'b0);
          end
        end
        i2cm_pkg::PH_REG: begin
          if (fl[i2cm_pkg::FL_TXE]) begin
            add_act(i2cm_pkg::ACT_ABYTE, p_reg, 1'b0);
            ph = (p_kind == i2cm_pkg::KIND_REGRD) ? i2cm_pkg::PH_REG2 : i2cm_pkg::PH_DATA;
          end else if (fl[i2cm_pkg::FL_AF]) begin
            abort_transfer(1'b1);
          end
        end
        i2cm_pkg::PH_DATA: begin
          if (fl[i2cm_pkg::FL_TXE]) begin
            add_act(i2cm_pkg::ACT_PAY, r.tx_byte, 1'b0);
            p_left = p_left - 1'b1;
            if (p_left == 0)
              ph = i2cm_pkg::PH_BTFTX;
          end else if (fl[i2cm_pkg::FL_AF]) begin
            abort_transfer(1'b1);
          end
        end
        i2cm_pkg::PH_BTFTX: begin
          if (fl[i2cm_pkg::FL_BTF])
            wrap_up();
        end
        i2cm_pkg::PH_REG2: begin
          // repeated start ahead of the read-back
          if (fl[i2cm_pkg::FL_TXE]) begin
            add_act(i2cm_pkg::ACT_START, 8'h00, 1'b0);
            ph = i2cm_pkg::PH_SB2;
          end else if (fl[i2cm_pkg::FL_AF]) begin
            abort_transfer(1'b1);
          end
        end
        i2cm_pkg::PH_RXONE: begin
          if (fl[i2cm_pkg::FL_RXNE]) begin
            add_act(i2cm_pkg::ACT_RX, r.rx_byte, 1'b0);
            wrap_up();
          end else if (fl[i2cm_pkg::FL_BERR]) begin
            abort_transfer(1'b0);
          end
        end
        i2cm_pkg::PH_RXN: begin
          if (fl[i2cm_pkg::FL_RXNE]) begin
            add_act(i2cm_pkg::ACT_RX, r.rx_byte, 1'b0);
            p_left = p_left - 1'b1;
            if (p_left <= 2)
              ph = i2cm_pkg::PH_RXBTF;
          end else if (fl[i2cm_pkg::FL_BERR]) begin
            abort_transfer(1'b0);
          end
        end
        i2cm_pkg::PH_RXBTF: begin
          // last two bytes read back to back with ACK turned off first
          if (fl[i2cm_pkg::FL_BTF]) begin
            add_act(i2cm_pkg::ACT_ACKOFF, 8'h00, 1'b0);
            add_act(i2cm_pkg::ACT_RX, r.rx_byte, 1'b0);
            add_act(i2cm_pkg::ACT_RX, r.rx_byte_second, 1'b0);
            p_left = '0;
            wrap_up();
          end else if (fl[i2cm_pkg::FL_BERR]) begin
            abort_transfer(1'b0);
          end
        end
        default: ph = i2cm_pkg::PH_IDLE;
      endcase
    end
    if (step_count > 0)
      step_acts[step_count-1].last = 1'b1;
  endtask

  task automatic queue_step_actions();
    for (int i = 0; i < step_count; i++)
      pending_actions.push_back(step_acts[i]);
  endtask

  // ------------------------------------------------------------------ sender
  task automatic offer(input i2cm_pkg::req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    compute_bus_actions(r);
  endtask

  task automatic sender_gap();
    if (!calm && tx_gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Flag a snapshot must carry (or, for BUSY, lack) to move the current wait forward
  function automatic int wanted_flag(logic [i2cm_pkg::PhaseBits-1:0] p);
    case (p)
      i2cm_pkg::PH_SB, i2cm_pkg::PH_SB2:                      return i2cm_pkg::FL_SB;
      i2cm_pkg::PH_ADDR, i2cm_pkg::PH_ADDR2:                  return i2cm_pkg::FL_ADDR;
      i2cm_pkg::PH_REG, i2cm_pkg::PH_DATA, i2cm_pkg::PH_REG2: return i2cm_pkg::FL_TXE;
      i2cm_pkg::PH_BTFTX, i2cm_pkg::PH_RXBTF:                 return i2cm_pkg::FL_BTF;
      i2cm_pkg::PH_RXONE, i2cm_pkg::PH_RXN:                   return i2cm_pkg::FL_RXNE;
      default:                                                return i2cm_pkg::FL_BUSY;
    endcase
  endfunction

  initial begin
    i2cm_pkg::req_t r;
    logic [95:0]    rnd;
    bit             ignored;
    bit             hold_fired;
    bit             drain_fired;
    int             counted;
    int             k;
    int             pick;
    int             wbit;

    hold_fired  = 1'b0;
    drain_fired = 1'b0;
    counted     = 0;
    k           = 0;

    // Directed table: idle and busy cases, all kinds, ACK rules, error exits
    plan.push_back(lit(snap(8'hFF, 8'h00, 8'h00, 8'h00), 0, NoAct, NoAct, NoAct));
    plan.push_back(lit(cmd(i2cm_pkg::KIND_WRITE, 7'h7F, 8'hFF, 16'h0000, 1'b1), 1,
                       bus_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1, 1'b1), NoAct, NoAct));
    plan.push_back(row(cmd(i2cm_pkg::KIND_WRITE, 7'h7F, 8'h00, 16'h0001, 1'b1)));
    plan.push_back(lit(cmd(i2cm_pkg::KIND_READ, 7'h00, 8'h00, 16'hFFFF, 1'b0), 0,
                       NoAct, NoAct, NoAct));
    plan.push_back(lit(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF), 0, NoAct, NoAct, NoAct));
    plan.push_back(lit(snap(8'h00, 8'h00, 8'h00, 8'h00), 1,
                       bus_act(i2cm_pkg::ACT_START, 8'h00, 1'b0, 1'b1), NoAct, NoAct));
    plan.push_back(lit(snap(8'h80, 8'h00, 8'h00, 8'h00), 3,
                       bus_act(i2cm_pkg::ACT_CLRBERR, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1, 1'b1)));
    plan.push_back(row(cmd(i2cm_pkg::KIND_REGRD, 7'h00, 8'hFF, 16'h0001, 1'b0)));
    plan.push_back(row(snap(8'h00, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h02, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'hC4, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h48, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h08, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h02, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h04, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'hA0, 8'h00, 8'hA5, 8'h5A)));
    plan.push_back(row(cmd(i2cm_pkg::KIND_REGWR, 7'h55, 8'h3C, 16'hFFFF, 1'b0)));
    plan.push_back(row(snap(8'hFE, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h02, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h04, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h08, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h08, 8'hFF, 8'h00, 8'h00)));
    plan.push_back(lit(snap(8'h40, 8'h00, 8'h00, 8'h00), 3,
                       bus_act(i2cm_pkg::ACT_CLRAF, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1, 1'b1)));
    plan.push_back(row(cmd(i2cm_pkg::KIND_WRITE, 7'h12, 8'h00, 16'h0001, 1'b0)));
    plan.push_back(row(snap(8'h00, 8'h00, 8'h00, 8'h00)));
    plan.push_back(row(snap(8'h02, 8'h00, 8'h00, 8'h00)));
    plan.push_back(lit(snap(8'hC0, 8'h00, 8'h00, 8'h00), 3,
                       bus_act(i2cm_pkg::ACT_CLRAF, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_STOP, 8'h00, 1'b0, 1'b0),
                       bus_act(i2cm_pkg::ACT_DONE, 8'h00, 1'b1, 1'b1)));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      offer(plan[i].r);
      if (plan[i].typed_on) begin
        for (int j = 0; j < plan[i].n_typed; j++)
          pending_actions.push_back(plan[i].typed[j]);
      end else begin
        queue_step_actions();
      end
      sender_gap();
    end

    // Random transfers, mostly well formed, shaped by the predicted phase
    while (counted < RandItems) begin
      rnd     = {$urandom, $urandom, $urandom};
      r       = rnd[$bits(i2cm_pkg::req_t)-1:0];
      ignored = 1'b0;
      if (ph == i2cm_pkg::PH_IDLE) begin
        if ($urandom_range(0, 9) == 0) begin
          r.req_type = i2cm_pkg::REQ_SNAP;
          ignored    = 1'b1;
        end else begin
          r.req_type = i2cm_pkg::REQ_CMD;
          pick       = $urandom_range(0, 99);
          if (pick < 4)
            r.byte_count = '0;
          else if (pick >= 9)
            r.byte_count = 16'($urandom_range(1, 6));
        end
      end else if ($urandom_range(0, 15) == 0) begin
        r.req_type = i2cm_pkg::REQ_CMD;
        ignored    = 1'b1;
      end else begin
        r.req_type = i2cm_pkg::REQ_SNAP;
        wbit       = wanted_flag(ph);
        if ($urandom_range(0, 11) != 0)
          r.status_flags[wbit] = (ph == i2cm_pkg::PH_BUSY) ? 1'b0 : 1'b1;
        else
          r.status_flags[wbit] = (ph == i2cm_pkg::PH_BUSY) ? 1'b1 : 1'b0;
      end

      if (!ignored)
        counted++;
      k++;
      if (k % 40 == 0) begin
        tx_gaps_on = ($urandom_range(0, 2) != 0);
        rx_gaps_on = ($urandom_range(0, 2) != 0);
      end
      if (counted >= RandItems - CalmItems)
        calm = 1'b1;
      if (counted == HoldAt && !hold_fired) begin
        hold_long  = 1'b1;
        hold_fired = 1'b1;
      end

      offer(r);
      queue_step_actions();

      if (counted == DrainAt && !drain_fired) begin
        drain_fired = 1'b1;
        req_valid  <= 1'b0;
        @(posedge clk);
        while (pending_actions.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        // long back-pressure so the block fills and stalls its input
        act_ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        hold_long = 1'b0;
        act_ready <= 1'b1;
      end else if (!calm && rx_gaps_on && $urandom_range(0, 3) == 0) begin
        act_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        act_ready <= 1'b1;
      end else begin
        act_ready <= 1'b1;
      end
    end
  end

  // ----------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst && act_valid && act_ready) begin
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected transaction action=%0d data=%h status=%b last=%b",
                 $time, act.action, act.data_byte, act.status, act.last);
        fails++;
      end else begin
        want = pending_actions.pop_front();
        if (act.action !== want.action) begin
          $display("%0t: action expected %0d actual %0d", $time, want.action, act.action);
          fails++;
        end
        if (act.data_byte !== want.data_byte) begin
          $display("%0t: data_byte expected %h actual %h", $time, want.data_byte,
                   act.data_byte);
          fails++;
        end
        if (act.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, act.status);
          fails++;
        end
        if (act.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $time, want.last, act.last);
          fails++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  initial begin
    forever begin
      @(posedge clk);
      if ((req_valid && req_ready) || (act_valid && act_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

endmodule
